// ===== src/hbia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbia_pkg: shared types and constants of the hierarchical bitmap allocator
// Field widths, bitmap geometry, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package hbia_pkg;

  // Bitmap geometry: 4096 IDs, 64 leaf words of 64 bits, one summary word
  localparam int unsigned MaxIds    = 4096;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned LeafWords = MaxIds / WordBits;
  localparam int unsigned BitW      = $clog2(WordBits);
  localparam int unsigned WordW     = $clog2(LeafWords);

  // Payload widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned IdW     = 12;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 13;
  localparam int unsigned LimitW  = 13;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(MaxIds);

  // Operation codes carried in func
  typedef enum logic [FuncW-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_IGNORED = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EVAL
  } state_e;

endpackage
`default_nettype wire

// ===== src/hbia_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbia_in_if: request channel of the allocator
// Valid/ready handshake carrying the operation and the target ID.
// ----------------------------------------------------------------------------
interface hbia_in_if;
  logic                        valid;
  logic                        ready;
  logic [hbia_pkg::FuncW-1:0]  func;
  logic [hbia_pkg::IdW-1:0]    target_id;

  modport source (output valid, output func, output target_id, input ready);
  modport sink   (input valid, input func, input target_id, output ready);
endinterface
`default_nettype wire

// ===== src/hbia_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbia_out_if: result channel of the allocator
// Valid/ready handshake carrying status, given ID, query answer and count.
// ----------------------------------------------------------------------------
interface hbia_out_if;
  logic                          valid;
  logic                          ready;
  logic [hbia_pkg::StatusW-1:0]  status;
  logic [hbia_pkg::IdW-1:0]      given_id;
  logic                          in_use;
  logic [hbia_pkg::CountW-1:0]   used_count;

  modport source (output valid, output status, output given_id, output in_use,
                  output used_count, input ready);
  modport sink   (input valid, input status, input given_id, input in_use,
                  input used_count, output ready);
endinterface
`default_nettype wire

// ===== src/hbia_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbia_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hbia_ram #(
  parameter int unsigned Width = hbia_pkg::WordBits,
  parameter int unsigned Depth = hbia_pkg::LeafWords
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, and register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/hierarchical_bitmap_id_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchical_bitmap_id_allocator: lowest-free ID allocator
// 64-ary bitmap: leaf words in RAM, one summary word of words with a free bit.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake         Payload
//  in_i     in         valid/ready       func, target_id
//  out_o    out        valid/ready       status, given_id, in_use, used_count
//  cfg      in         cfg_we_i          cfg_wdata_i -> id_limit
//
//  Each item is accepted, then goes through summary search and leaf read, then
//  leaf evaluation and write-back. One find-first-set unit serves both steps.
//  Ready is high only while the sequencer is idle. A result waits in the output
//  register; a stalled output holds the item in evaluation until the slot frees.
//  Reset leaves ID 0 reserved; leaf words read as reset values until written.
// ----------------------------------------------------------------------------
module hierarchical_bitmap_id_allocator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [hbia_pkg::LimitW-1:0]  cfg_wdata_i,
  hbia_in_if.sink                           in_i,
  hbia_out_if.source                        out_o
);

  localparam int unsigned WB = hbia_pkg::WordBits;
  localparam int unsigned BW = hbia_pkg::BitW;
  localparam int unsigned WW = hbia_pkg::WordW;

  hbia_pkg::state_e state_q, state_d;

  logic [hbia_pkg::FuncW-1:0]   func_q;
  logic [hbia_pkg::IdW-1:0]     tgt_q;
  logic [hbia_pkg::LimitW-1:0]  limit_q;
  logic [hbia_pkg::CountW-1:0]  total_q, total_d;
  logic [WB-1:0]                mid_q, mid_d;
  logic [hbia_pkg::LeafWords-1:0] leaf_vld_q;
  logic [WW-1:0]                word_q;
  logic                         rd_vld_q;
  logic                         mid_hit_q;

  logic                         out_vld_q;
  logic [hbia_pkg::StatusW-1:0] status_q, status_d;
  logic [hbia_pkg::IdW-1:0]     given_q, given_d;
  logic                         in_use_q, in_use_d;

  // Shared find-first-set unit
  logic [WB-1:0] ffs_in;
  logic [BW-1:0] ffs_idx;
  logic          ffs_found;

  // RAM port signals
  logic          ram_we;
  logic [WB-1:0] ram_wdata;
  logic          ram_re;
  logic [WW-1:0] look_word;
  logic [WB-1:0] ram_rdata;

  logic          accept;
  logic          out_free;
  logic          commit;
  logic [WB-1:0] leaf;
  logic [WB-1:0] leaf_set;
  logic [WB-1:0] leaf_clr;
  logic [hbia_pkg::IdW-1:0] alloc_id;
  logic          tgt_ok;
  logic          tgt_used;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign commit   = (state_q == hbia_pkg::S_EVAL) && out_free;

  // Leaf word as read, with unwritten words at their reset value
  assign leaf = rd_vld_q ? ram_rdata :
                ((word_q == '0) ? WB'(1) : '0);

  // Select the search operand: summary while looking, free bits while evaluating
  assign ffs_in = (state_q == hbia_pkg::S_LOOK) ? mid_q : ~leaf;

  // Lowest set bit of the operand
  always_comb begin
    ffs_idx   = '0;
    ffs_found = |ffs_in;
    for (int i = WB - 1; i >= 0; i--) begin
      if (ffs_in[i]) begin
        ffs_idx = BW'(i);
      end
    end
  end

  // Pick the leaf word: lowest word with a free bit, or the target's word
  assign look_word = (func_q == hbia_pkg::OP_ALLOC) ? ffs_idx : tgt_q[hbia_pkg::IdW-1:BW];
  assign ram_re    = (state_q == hbia_pkg::S_LOOK);

  assign alloc_id = {word_q, ffs_idx};
  assign tgt_ok   = (tgt_q != '0) || (func_q == hbia_pkg::OP_QUERY);
  assign tgt_used = ({1'b0, tgt_q} < limit_q) && leaf[tgt_q[BW-1:0]];
  assign leaf_set = leaf | (WB'(1) << ffs_idx);
  assign leaf_clr = leaf & ~(WB'(1) << tgt_q[BW-1:0]);

  // Evaluate the operation on the leaf word
  always_comb begin
    status_d  = hbia_pkg::STAT_DONE;
    given_d   = '0;
    in_use_d  = 1'b0;
    total_d   = total_q;
    mid_d     = mid_q;
    ram_we    = 1'b0;
    ram_wdata = leaf;
    unique case (func_q)
      hbia_pkg::OP_ALLOC: begin
        if (mid_hit_q && ffs_found && ({1'b0, alloc_id} < limit_q)) begin
          given_d   = alloc_id;
          total_d   = total_q + 1'b1;
          ram_we    = commit;
          ram_wdata = leaf_set;
          if (&leaf_set) begin
            mid_d[word_q] = 1'b0;
          end
        end else begin
          status_d = hbia_pkg::STAT_FULL;
        end
      end
      hbia_pkg::OP_RELEASE: begin
        if (tgt_ok && tgt_used) begin
          total_d       = total_q - 1'b1;
          ram_we        = commit;
          ram_wdata     = leaf_clr;
          mid_d[word_q] = 1'b1;
        end else begin
          status_d = hbia_pkg::STAT_IGNORED;
        end
      end
      hbia_pkg::OP_QUERY: begin
        in_use_d = tgt_used;
      end
      default: begin
      end
    endcase
  end

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hbia_pkg::S_IDLE: begin
        if (accept) begin
          state_d = hbia_pkg::S_LOOK;
        end
      end
      hbia_pkg::S_LOOK: begin
        state_d = hbia_pkg::S_EVAL;
      end
      hbia_pkg::S_EVAL: begin
        if (out_free) begin
          state_d = hbia_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hbia_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_i.ready        = (state_q == hbia_pkg::S_IDLE);
    out_o.valid       = out_vld_q;
    out_o.status      = status_q;
    out_o.given_id    = given_q;
    out_o.in_use      = in_use_q;
    out_o.used_count  = total_q;
  end

  // Control state: sequencer, summary, count, limit, valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hbia_pkg::S_IDLE;
      mid_q      <= '1;
      total_q    <= hbia_pkg::CountW'(1);
      limit_q    <= hbia_pkg::LimitReset;
      leaf_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (commit) begin
        mid_q     <= mid_d;
        total_q   <= total_d;
        out_vld_q <= 1'b1;
        if (ram_we) begin
          leaf_vld_q[word_q] <= 1'b1;
        end
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: request, leaf read bookkeeping, result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_i.func;
      tgt_q  <= in_i.target_id;
    end
    if (ram_re) begin
      word_q    <= look_word;
      rd_vld_q  <= leaf_vld_q[look_word];
      mid_hit_q <= ffs_found;
    end
    if (commit) begin
      status_q <= status_d;
      given_q  <= given_d;
      in_use_q <= in_use_d;
    end
  end

  hbia_ram #(
    .Width (WB),
    .Depth (hbia_pkg::LeafWords)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (look_word),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire

// ===== src/hbia_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbia_checker: port-level checks of the allocator
// Watches both channels and the result fields; attached by bind.
// ----------------------------------------------------------------------------
module hbia_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [hbia_pkg::StatusW-1:0]  status_i,
  input wire logic [hbia_pkg::IdW-1:0]      given_id_i,
  input wire logic                          in_use_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(given_id_i) && $stable(in_use_i))
    else $error("stalled result changed");

  // Drop ready after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while busy");

  // No ID on a failed or ignored operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != hbia_pkg::STAT_DONE) |-> given_id_i == '0 && !in_use_i)
    else $error("payload set on a failed operation");

  // A nonzero given ID comes only with a done status and no query answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (given_id_i != '0) |-> status_i == hbia_pkg::STAT_DONE && !in_use_i)
    else $error("allocation result inconsistent");

endmodule

bind hierarchical_bitmap_id_allocator hbia_checker u_hbia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .given_id_i  (out_o.given_id),
  .in_use_i    (out_o.in_use)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the hierarchical bitmap ID allocator
// Requests are queued by a stimulus process and driven with random gaps. An
// in-bench model of the bitmap computes each answer when its request is
// accepted, and a monitor compares every result field with the oldest answer.
// The run covers several ID limits, a bitmap filled up to its limit and a long
// churn of random allocate, release and query requests.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned FuncW      = hbia_pkg::FuncW;
  localparam int unsigned IdW        = hbia_pkg::IdW;
  localparam int unsigned CountW     = hbia_pkg::CountW;
  localparam int unsigned LimitW     = hbia_pkg::LimitW;
  localparam int unsigned MaxIds     = hbia_pkg::MaxIds;
  localparam int unsigned WordBits   = hbia_pkg::WordBits;
  localparam int unsigned LeafWords  = hbia_pkg::LeafWords;
  localparam logic [LimitW-1:0] LimitReset = hbia_pkg::LimitReset;

  localparam logic [FuncW-1:0] OpUnused = 2'd3;
  localparam int unsigned HalfPeriod   = 10;
  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned IdlePct      = 7;
  localparam int unsigned FillLimit    = 256;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [IdW-1:0]   target_id;
  } request_t;

  typedef struct packed {
    hbia_pkg::status_e status;
    logic [IdW-1:0]    given_id;
    logic              in_use;
    logic [CountW-1:0] used_count;
  } answer_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LimitW-1:0] cfg_wdata_i;

  hbia_in_if  req_if ();
  hbia_out_if rsp_if ();

  hierarchical_bitmap_id_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  // Bitmap model: one bit per ID, plus the words that still have room
  logic [WordBits-1:0]  held_map [LeafWords];
  logic [LeafWords-1:0] words_with_room;
  logic [CountW-1:0]    held_total;
  logic [LimitW-1:0]    limit_shadow;

  request_t pending_reqs [$];
  answer_t  answers_due  [$];
  answer_t  wanted_answer;

  bit no_idle;
  int mismatch_count;
  int idle_cycles;
  int limit_writes;
  int op_tally [4];
  int full_answers;
  int ignored_answers;
  int peak_count;

  // Clock
  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  function automatic int lowest_one(logic [WordBits-1:0] w);
    int i;
    lowest_one = WordBits;
    for (i = WordBits - 1; i >= 0; i--) begin
      if (w[i]) lowest_one = i;
    end
  endfunction

  function automatic int usable_ids();
    return (limit_shadow < MaxIds) ? int'(limit_shadow) : int'(MaxIds);
  endfunction

  function automatic bit is_held(int id);
    return held_map[id / WordBits][id % WordBits];
  endfunction

  // Apply one request to the bitmap model and return the answer it must give
  function automatic answer_t serve_request(request_t rq);
    answer_t ans;
    int      word_idx;
    int      bit_idx;
    int      id;
    ans.status   = hbia_pkg::STAT_DONE;
    ans.given_id = '0;
    ans.in_use   = 1'b0;
    id           = int'(rq.target_id);
    case (rq.func)
      hbia_pkg::OP_ALLOC: begin
        word_idx = lowest_one(words_with_room);
        bit_idx  = 0;
        if (word_idx < LeafWords) begin
          bit_idx = lowest_one(~held_map[word_idx]);
          id      = word_idx * WordBits + bit_idx;
        end else begin
          id = MaxIds;
        end
        if (id >= usable_ids()) begin
          ans.status = hbia_pkg::STAT_FULL;
        end else begin
          held_map[word_idx][bit_idx] = 1'b1;
          held_total   = held_total + 1'b1;
          ans.given_id = IdW'(id);
          if (&held_map[word_idx]) words_with_room[word_idx] = 1'b0;
        end
      end
      hbia_pkg::OP_RELEASE: begin
        if (id == 0 || id >= usable_ids() || !is_held(id)) begin
          ans.status = hbia_pkg::STAT_IGNORED;
        end else begin
          held_map[id / WordBits][id % WordBits] = 1'b0;
          held_total = held_total - 1'b1;
          words_with_room[id / WordBits] = 1'b1;
        end
      end
      hbia_pkg::OP_QUERY: begin
        if (id < usable_ids()) ans.in_use = is_held(id);
      end
      default: begin
      end
    endcase
    ans.used_count = held_total;
    return ans;
  endfunction

  // Pick an ID that is probably in use, starting from a random point
  function automatic logic [IdW-1:0] pick_held();
    int start;
    int k;
    int id;
    start = (usable_ids() > 1) ? $urandom_range(usable_ids() - 1)
                               : $urandom_range(MaxIds - 1);
    for (k = 0; k < MaxIds; k++) begin
      id = (start + k) % MaxIds;
      if (id != 0 && is_held(id)) return IdW'(id);
    end
    return IdW'(start);
  endfunction

  // Request driver: predict on acceptance, then present the next item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        answers_due.push_back(serve_request('{req_if.func, req_if.target_id}));
        op_tally[req_if.func]++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
          req_if.valid     <= 1'b1;
          req_if.func      <= pending_reqs[0].func;
          req_if.target_id <= pending_reqs[0].target_id;
          pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest answer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result: status %0d given_id %0d in_use %0d",
                   $time, rsp_if.status, rsp_if.given_id, rsp_if.in_use);
          $display("%0t: unexpected result: used_count %0d", $time, rsp_if.used_count);
          mismatch_count++;
        end else begin
          wanted_answer = answers_due.pop_front();
          if (rsp_if.status !== wanted_answer.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, wanted_answer.status, rsp_if.status);
            mismatch_count++;
          end
          if (rsp_if.given_id !== wanted_answer.given_id) begin
            $display("%0t: given_id expected %0d actual %0d",
                     $time, wanted_answer.given_id, rsp_if.given_id);
            mismatch_count++;
          end
          if (rsp_if.in_use !== wanted_answer.in_use) begin
            $display("%0t: in_use expected %0d actual %0d",
                     $time, wanted_answer.in_use, rsp_if.in_use);
            mismatch_count++;
          end
          if (rsp_if.used_count !== wanted_answer.used_count) begin
            $display("%0t: used_count expected %0d actual %0d",
                     $time, wanted_answer.used_count, rsp_if.used_count);
            mismatch_count++;
          end
          if (wanted_answer.status == hbia_pkg::STAT_FULL) full_answers++;
          if (wanted_answer.status == hbia_pkg::STAT_IGNORED) ignored_answers++;
          if (int'(wanted_answer.used_count) > peak_count) begin
            peak_count = int'(wanted_answer.used_count);
          end
        end
      end
      rsp_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // Watchdog: give up when nothing has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we_i)
    begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Hold back until the queue has room, then append one item
  task automatic queue_request(input logic [FuncW-1:0] op, input logic [IdW-1:0] tgt);
    while (pending_reqs.size() >= 2) @(negedge clk_i);
    pending_reqs.push_back('{op, tgt});
  endtask

  // Wait until the block is idle and every answer has arrived
  task automatic drain();
    while (pending_reqs.size() != 0 || req_if.valid || answers_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    limit_shadow = value;
    limit_writes++;
  endtask

  // Mostly allocate and release of held IDs; the rest queries and noise
  task automatic random_requests(input int count, input int alloc_pct, input int free_pct);
    int k;
    int roll;
    for (k = 0; k < count; k++) begin
      while (pending_reqs.size() >= 2) @(negedge clk_i);
      roll = $urandom_range(99);
      if (roll < alloc_pct)
        queue_request(hbia_pkg::OP_ALLOC, IdW'($urandom_range(MaxIds - 1)));
      else if (roll < alloc_pct + free_pct)
        queue_request(hbia_pkg::OP_RELEASE, pick_held());
      else if (roll < alloc_pct + free_pct + 8)
        queue_request(hbia_pkg::OP_QUERY, pick_held());
      else if (roll < 94)
        queue_request(hbia_pkg::OP_QUERY, IdW'($urandom_range(MaxIds - 1)));
      else if (roll < 98)
        queue_request(hbia_pkg::OP_RELEASE, IdW'($urandom_range(MaxIds - 1)));
      else
        queue_request(OpUnused, IdW'($urandom_range(MaxIds - 1)));
    end
  endtask

  // Stimulus
  initial begin
    int k;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    req_if.valid     = 1'b0;
    req_if.func      = hbia_pkg::OP_ALLOC;
    req_if.target_id = '0;
    rsp_if.ready     = 1'b0;
    no_idle          = 1'b0;
    for (k = 0; k < LeafWords; k++) held_map[k] = '0;
    held_map[0][0]  = 1'b1;
    words_with_room = '1;
    held_total      = 1;
    limit_shadow    = LimitReset;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reserved ID, lowest-free order, double release, unused code
    queue_request(hbia_pkg::OP_QUERY, 12'd0);
    queue_request(hbia_pkg::OP_QUERY, 12'hFFF);
    queue_request(hbia_pkg::OP_ALLOC, 12'hFFF);
    queue_request(hbia_pkg::OP_ALLOC, 12'd0);
    queue_request(hbia_pkg::OP_ALLOC, 12'd0);
    queue_request(hbia_pkg::OP_RELEASE, 12'd0);
    queue_request(hbia_pkg::OP_RELEASE, 12'd2);
    queue_request(hbia_pkg::OP_RELEASE, 12'd2);
    queue_request(hbia_pkg::OP_QUERY, 12'd2);
    queue_request(hbia_pkg::OP_QUERY, 12'd3);
    queue_request(hbia_pkg::OP_ALLOC, 12'd0);
    queue_request(hbia_pkg::OP_RELEASE, 12'hFFF);
    queue_request(OpUnused, 12'hFFF);
    queue_request(OpUnused, 12'd0);
    queue_request(hbia_pkg::OP_RELEASE, 12'd1);
    queue_request(hbia_pkg::OP_ALLOC, 12'd0);
    queue_request(hbia_pkg::OP_QUERY, 12'd1);

    // Limit just past one word: fill it, then churn at the edge
    write_limit(13'd70);
    random_requests(150, 60, 25);
    // Only the reserved ID usable; higher IDs stay counted
    write_limit(13'd1);
    random_requests(30, 40, 30);
    // No usable IDs at all
    write_limit(13'd0);
    random_requests(30, 40, 30);
    // Limit above the bitmap size
    write_limit(13'h1FFF);
    random_requests(120, 45, 40);
    write_limit(13'd65);
    random_requests(60, 60, 25);
    write_limit(LimitW'($urandom_range(4095, 2)));
    random_requests(100, 45, 40);

    // Fill every ID below the limit without idling, then churn and refill
    write_limit(LimitW'(FillLimit));
    no_idle = 1'b1;
    for (k = 0; k < FillLimit + 4; k++) begin
      queue_request(hbia_pkg::OP_ALLOC, IdW'($urandom_range(MaxIds - 1)));
    end
    drain();
    no_idle = 1'b0;
    random_requests(80, 30, 50);
    random_requests(60, 60, 25);

    drain();
    $display("Ran %0d requests: %0d allocate, %0d release, %0d query, %0d unused code",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
    $display("%0d limit writes, %0d no-free-ID answers, %0d ignored releases, peak count %0d",
             limit_writes, full_answers, ignored_answers, peak_count);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
